FILE: hw/rtl/acp_pkg.sv
// shared types, constants and aes round functions for the ctr payload cipher
`timescale 1ns / 1ps
package acp_pkg;

    localparam int DATA_W = 8;
    localparam int FC_W = 32;
    localparam int KEY_W = 64;
    localparam int BLK_W = 128;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int ROUNDS = 10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [FC_W-1:0]   fc;
        logic              last;
        logic              new_blk;
        logic [7:0]        blk;
        logic [3:0]        off;
    } word_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // one round: subbytes, shiftrows, mixcolumns unless final
    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic fin);
        logic [7:0] r [16];
        logic [7:0] a0, a1, a2, a3, t;
        logic [BLK_W-1:0] o;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                src = i + 4 * ((c + i) % 4);
                r[i + 4 * c] = SBOX[s[src * 8 +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = r[4 * c];
            a1 = r[4 * c + 1];
            a2 = r[4 * c + 2];
            a3 = r[4 * c + 3];
            t = a0 ^ a1 ^ a2 ^ a3;
            if (!fin) begin
                r[4 * c]     = a0 ^ t ^ xtime(a0 ^ a1);
                r[4 * c + 1] = a1 ^ t ^ xtime(a1 ^ a2);
                r[4 * c + 2] = a2 ^ t ^ xtime(a2 ^ a3);
                r[4 * c + 3] = a3 ^ t ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[i * 8 +: 8] = r[i];
        end
        aes_round = o;
    endfunction

    // next round key from the current one
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rc);
        logic [31:0] t;
        logic [BLK_W-1:0] o;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        o[31:0]   = k[31:0] ^ t;
        o[63:32]  = k[63:32] ^ o[31:0];
        o[95:64]  = k[95:64] ^ o[63:32];
        o[127:96] = k[127:96] ^ o[95:64];
        key_step = o;
    endfunction

endpackage

FILE: hw/rtl/acp_front.sv
// front end: takes input words, tracks counters and tags keystream needs
`timescale 1ns / 1ps
module acp_front
    import acp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_data_byte,
    input  logic              s_opcode,
    input  logic [FC_W-1:0]   s_frame_count_in,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    input  logic              key_wr,
    output logic              push,
    output word_t             push_word,
    input  logic              q_ready
);

    logic [FC_W-1:0] tx_reg, tx_next;
    logic [FC_W-1:0] pc_reg, pc_next;
    logic [7:0]      blk_reg, blk_next;
    logic [3:0]      off_reg, off_next;
    logic [FC_W-1:0] pc_use;
    logic [7:0]      blk_use;
    logic [3:0]      off_use;

    assign s_ready = q_ready;
    assign push = s_valid && q_ready;

    always_comb begin
        pc_use = s_first_byte ? (s_opcode ? s_frame_count_in : tx_reg) : pc_reg;
        blk_use = s_first_byte ? 8'd0 : blk_reg;
        off_use = s_first_byte ? 4'd0 : off_reg;
        push_word.data = s_data_byte;
        push_word.fc = pc_use;
        push_word.last = s_last_byte;
        push_word.new_blk = (off_use == 4'd0);
        push_word.blk = blk_use;
        push_word.off = off_use;
        tx_next = tx_reg;
        pc_next = pc_reg;
        blk_next = blk_reg;
        off_next = off_reg;
        if (push) begin
            if (s_first_byte && !s_opcode) begin
                tx_next = tx_reg + 32'd1;
            end
            pc_next = pc_use;
            off_next = off_use + 4'd1;
            blk_next = (off_use == 4'd15) ? blk_use + 8'd1 : blk_use;
        end
        if (key_wr) begin
            tx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg <= '0;
            pc_reg <= '0;
            blk_reg <= '0;
            off_reg <= '0;
        end else begin
            tx_reg <= tx_next;
            pc_reg <= pc_next;
            blk_reg <= blk_next;
            off_reg <= off_next;
        end
    end

endmodule

FILE: hw/rtl/acp_queue.sv
// small word queue between front and back
`timescale 1ns / 1ps
module acp_queue
    import acp_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  word_t push_word,
    output logic  q_ready,
    input  logic  pop,
    output logic  q_valid,
    output word_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full = CntW'(Depth);

    word_t           mem [Depth];
    logic [PtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign q_ready = (cnt_reg != Full);
    assign q_valid = (cnt_reg != '0);
    assign head = mem[rd_reg];

    always_comb begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == LastPtr) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == LastPtr) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/acp_back.sv
// back end: iterative aes keystream engine, xor and output register
`timescale 1ns / 1ps
module acp_back
    import acp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BLK_W-1:0]  key,
    input  logic              q_valid,
    input  word_t             head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_data_out,
    output logic [FC_W-1:0]   m_frame_count_used,
    output logic              m_last_out
);

    logic              busy_reg, busy_next;
    logic              fresh_reg, fresh_next;
    logic [3:0]        rnd_reg, rnd_next;
    logic [7:0]        rc_reg, rc_next;
    logic [BLK_W-1:0]  st_reg, st_next;
    logic [BLK_W-1:0]  rk_reg, rk_next;
    logic [BLK_W-1:0]  ks_reg, ks_next;
    logic              mv_reg, mv_next;
    logic [DATA_W-1:0] md_reg, md_next;
    logic [FC_W-1:0]   mf_reg, mf_next;
    logic              ml_reg, ml_next;
    logic              out_can, start;
    logic [BLK_W-1:0]  ctr, rk_step, st_step;

    assign out_can = !mv_reg || m_ready;
    assign pop = q_valid && out_can && (!head.new_blk || fresh_reg);
    assign start = q_valid && head.new_blk && !fresh_reg && !busy_reg;
    assign m_valid = mv_reg;
    assign m_data_out = md_reg;
    assign m_frame_count_used = mf_reg;
    assign m_last_out = ml_reg;

    always_comb begin
        ctr = '0;
        ctr[FC_W-1:0] = head.fc;
        ctr[BLK_W-1 -: 8] = head.blk + 8'd1;
        rk_step = key_step(rk_reg, rc_reg);
        st_step = aes_round(st_reg, rnd_reg == 4'(ROUNDS)) ^ rk_step;
        busy_next = busy_reg;
        fresh_next = fresh_reg;
        rnd_next = rnd_reg;
        rc_next = rc_reg;
        st_next = st_reg;
        rk_next = rk_reg;
        ks_next = ks_reg;
        if (start) begin
            busy_next = 1'b1;
            rnd_next = 4'd1;
            rc_next = 8'h01;
            st_next = ctr ^ key;
            rk_next = key;
        end else if (busy_reg) begin
            rnd_next = rnd_reg + 4'd1;
            rc_next = xtime(rc_reg);
            st_next = st_step;
            rk_next = rk_step;
            if (rnd_reg == 4'(ROUNDS)) begin
                busy_next = 1'b0;
                fresh_next = 1'b1;
                ks_next = st_step;
            end
        end
        if (pop && head.new_blk) begin
            fresh_next = 1'b0;
        end
        mv_next = mv_reg;
        md_next = md_reg;
        mf_next = mf_reg;
        ml_next = ml_reg;
        if (out_can) begin
            mv_next = pop;
        end
        if (pop) begin
            md_next = head.data ^ ks_reg[{head.off, 3'b000} +: 8];
            mf_next = head.fc;
            ml_next = head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fresh_reg <= 1'b0;
            mv_reg <= 1'b0;
            rnd_reg <= '0;
            rc_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            fresh_reg <= fresh_next;
            mv_reg <= mv_next;
            rnd_reg <= rnd_next;
            rc_reg <= rc_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        rk_reg <= rk_next;
        ks_reg <= ks_next;
        md_reg <= md_next;
        mf_reg <= mf_next;
        ml_reg <= ml_next;
    end

endmodule

FILE: hw/rtl/aes_ctr_payload_cipher.sv
// top level of the aes-128 ctr payload cipher
// usage:
//   s_ channel carries one payload byte per word with first/last marks,
//   opcode and the decrypt frame counter; m_ channel returns one word per
//   input word in order: data xor keystream, counter used, last mark.
//   cfg_we writes key_low (index 0) or key_high (index 1); either write
//   clears the transmit frame counter. write only while the block is idle.
// data path:
//   a word that needs no new keystream block passes the queue and the
//   output register; a word that opens a 16-byte block first waits for
//   the iterative aes core, one round per cycle; the single round unit sets
//   the sustained rate, starting a block when its first word heads the
//   queue. the queue holds words meanwhile; input flows until it is full.
// reset: counters clear, key is all zero, queue and output empty.
// stall: a held m_ word stays stable; the queue fills, then s_ready drops.
`timescale 1ns / 1ps
module aes_ctr_payload_cipher
    import acp_pkg::*;
#(
    parameter int QDepth = QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_data_byte,
    input  logic                 s_opcode,
    input  logic [FC_W-1:0]      s_frame_count_in,
    input  logic                 s_first_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_data_out,
    output logic [FC_W-1:0]      m_frame_count_used,
    output logic                 m_last_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    logic [KEY_W-1:0] key_low_reg, key_high_reg;
    logic             key_wr, push, q_ready, q_valid, pop;
    word_t            push_word, head;

    assign key_wr = cfg_we && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg <= '0;
            key_high_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end else if (cfg_index == REG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end
        end
    end

    acp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_opcode(s_opcode),
        .s_frame_count_in(s_frame_count_in),
        .s_first_byte(s_first_byte), .s_last_byte(s_last_byte),
        .key_wr(key_wr), .push(push), .push_word(push_word), .q_ready(q_ready)
    );

    acp_queue #(.Depth(QDepth)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_word(push_word), .q_ready(q_ready),
        .pop(pop), .q_valid(q_valid), .head(head)
    );

    acp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .key({key_high_reg, key_low_reg}),
        .q_valid(q_valid), .head(head), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_data_out(m_data_out), .m_frame_count_used(m_frame_count_used),
        .m_last_out(m_last_out)
    );

endmodule

FILE: hw/rtl/acp_checker.sv
// port-level checks for the ctr payload cipher, bound to the top level
`timescale 1ns / 1ps
module acp_checker
    import acp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_data_out,
    input logic [FC_W-1:0]   m_frame_count_used,
    input logic              m_last_out
);

    // output register empties on reset
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    // queue is empty after reset, so input is open
    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data_out) && $stable(m_frame_count_used)
            && $stable(m_last_out))
        else $error("m_ word changed while stalled");

endmodule

bind aes_ctr_payload_cipher acp_checker u_acp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data_out(m_data_out),
    .m_frame_count_used(m_frame_count_used), .m_last_out(m_last_out)
);
